// File: rtl/lpda_pkg.sv
// Shared types and constants for the LUT product dot-accumulate block.
// Used by lpda_table, lpda_accum and lut_product_dot_accumulate; no dependencies.
package lpda_pkg;

    localparam int OPERAND_W        = 8;
    localparam int OPERAND_BITS_DEF = 8;
    localparam int TABLE_VALUE_W    = 16;
    localparam int SUM_W            = 32;

    typedef enum logic {
        KIND_TABLE_WRITE = 1'b0,
        KIND_MAC         = 1'b1
    } t_kind;

    // Control for one multiply-accumulate step leaving the table read stage.
    typedef struct packed {
        logic valid;
        logic last;
    } t_step;

endpackage

// File: rtl/lpda_table.sv
// Product table: a single-port synchronous memory with registered read data.
// Depends on lpda_pkg for widths.
module lpda_table #(
    parameter int OPERAND_BITS = lpda_pkg::OPERAND_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic                                    i_rd_en,
    input  logic                                    i_swap,
    input  logic [lpda_pkg::OPERAND_W-1:0]          i_first_operand,
    input  logic [lpda_pkg::OPERAND_W-1:0]          i_second_operand,
    input  logic signed [lpda_pkg::TABLE_VALUE_W-1:0] i_wr_value,
    output logic signed [lpda_pkg::TABLE_VALUE_W-1:0] o_rd_data
);

    localparam int ADDR_W = 2 * OPERAND_BITS;
    localparam int DEPTH  = 1 << ADDR_W;

    logic [lpda_pkg::TABLE_VALUE_W-1:0] r_mem [DEPTH];
    logic [lpda_pkg::TABLE_VALUE_W-1:0] r_rd_data;
    logic [OPERAND_BITS-1:0]            row_idx;
    logic [OPERAND_BITS-1:0]            col_idx;
    logic [ADDR_W-1:0]                  addr;

    // Writes always use first operand as row; reads follow the swap bit.
    always_comb begin
        if (i_rd_en && i_swap) begin
            row_idx = i_second_operand[OPERAND_BITS-1:0];
            col_idx = i_first_operand[OPERAND_BITS-1:0];
        end else begin
            row_idx = i_first_operand[OPERAND_BITS-1:0];
            col_idx = i_second_operand[OPERAND_BITS-1:0];
        end
        addr = {row_idx, col_idx};
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[addr] <= i_wr_value;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/lpda_accum.sv
// Running-sum register and output register of the dot-accumulate block.
// Depends on lpda_pkg for widths and the step control struct.
module lpda_accum (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  lpda_pkg::t_step                           i_step,
    input  logic signed [lpda_pkg::TABLE_VALUE_W-1:0] i_product,
    output logic                                      o_hold,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [lpda_pkg::SUM_W-1:0]         o_dot_sum
);

    localparam int EXT_W = lpda_pkg::SUM_W - lpda_pkg::TABLE_VALUE_W;

    lpda_pkg::t_step                  r_step;
    lpda_pkg::t_step                  n_step;
    logic [lpda_pkg::SUM_W-1:0]       r_sum;
    logic [lpda_pkg::SUM_W-1:0]       n_sum;
    logic [lpda_pkg::SUM_W-1:0]       r_out;
    logic [lpda_pkg::SUM_W-1:0]       n_out;
    logic                             r_out_valid;
    logic                             n_out_valid;
    logic [lpda_pkg::SUM_W-1:0]       total;
    logic                             step_go;

    assign total = r_sum + {{EXT_W{i_product[lpda_pkg::TABLE_VALUE_W-1]}}, i_product};

    // A last step needs a free output register; other steps always move.
    assign step_go = r_step.valid && (!r_step.last || !r_out_valid || !i_out_stall);
    assign o_hold  = r_step.valid && !step_go;

    always_comb begin
        n_step      = o_hold ? r_step : i_step;
        n_sum       = r_sum;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (step_go) begin
            if (r_step.last) begin
                n_sum       = '0;
                n_out       = total;
                n_out_valid = 1'b1;
            end else begin
                n_sum = total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_dot_sum   = r_out;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_go && r_step.last) |=> (r_sum == '0))
        else $error("running sum not cleared after last step");

    a_accumulate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_go && !r_step.last) |=> (r_sum == $past(total)))
        else $error("running sum did not add the product");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(step_go && r_step.last))
        else $error("result appeared without a last step");

    a_hold_keeps_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hold |=> (r_step.valid && r_step.last))
        else $error("held step was lost");
`endif

endmodule

// File: rtl/lut_product_dot_accumulate.sv
// Top level of the LUT product dot-accumulate block.
// Depends on lpda_pkg, lpda_table and lpda_accum.
//
// Accepts one transaction per clock cycle while input stall is low, table writes and
// multiply-accumulate steps alike: each uses the table memory's single port once, and
// the accumulator adds one product per cycle while no last step is held. A result is
// loaded into the output register from the registered table product and step, and is
// held there until taken. Input stall rises only when a last step waits for the output
// register while a previous result is still stalled. The table has no reset and no
// clearing pass; entries must be written before they are read.
module lut_product_dot_accumulate #(
    parameter int OPERAND_BITS = lpda_pkg::OPERAND_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic                                      i_cfg_wdata,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic                                      i_kind,
    input  logic [lpda_pkg::OPERAND_W-1:0]            i_first_operand,
    input  logic [lpda_pkg::OPERAND_W-1:0]            i_second_operand,
    input  logic signed [lpda_pkg::TABLE_VALUE_W-1:0] i_table_value,
    input  logic                                      i_last,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [lpda_pkg::SUM_W-1:0]         o_dot_sum
);

    logic                                      r_swap;
    logic                                      in_accept;
    logic                                      wr_en;
    logic                                      rd_en;
    logic                                      hold;
    logic signed [lpda_pkg::TABLE_VALUE_W-1:0] product;
    lpda_pkg::t_step                           step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap <= 1'b0;
        end else if (i_cfg_we) begin
            r_swap <= i_cfg_wdata;
        end
    end

    assign o_in_stall = hold;
    assign in_accept  = i_in_valid && !hold;
    assign wr_en      = in_accept && (lpda_pkg::t_kind'(i_kind) == lpda_pkg::KIND_TABLE_WRITE);
    assign rd_en      = in_accept && (lpda_pkg::t_kind'(i_kind) == lpda_pkg::KIND_MAC);

    always_comb begin
        step.valid = rd_en;
        step.last  = i_last;
    end

    lpda_table #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_table (
        .i_clk            (i_clk),
        .i_wr_en          (wr_en),
        .i_rd_en          (rd_en),
        .i_swap           (r_swap),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_wr_value       (i_table_value),
        .o_rd_data        (product)
    );

    lpda_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_product   (product),
        .o_hold      (hold),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dot_sum   (o_dot_sum)
    );

endmodule

// File: dv/tb_lut_product_dot_accumulate.sv
// Self-checking testbench for lut_product_dot_accumulate: a queued driver, a result monitor
// and a transaction-level predictor of the table lookup and the wrapping dot-product sum.
// Depends on lpda_pkg and the RTL of lut_product_dot_accumulate.
`timescale 1ns / 1ps

module tb_lut_product_dot_accumulate;

    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 270;
    localparam int EXTREME_ITEMS  = 32;

    typedef struct {
        lpda_pkg::t_kind                          kind;
        logic [lpda_pkg::OPERAND_W-1:0]           first_op;
        logic [lpda_pkg::OPERAND_W-1:0]           second_op;
        logic signed [lpda_pkg::TABLE_VALUE_W-1:0] value;
        logic                                     last;
    } t_mac_item;

    logic                                      i_clk = 1'b0;
    logic                                      i_rst_n = 1'b0;
    logic                                      i_cfg_we = 1'b0;
    logic                                      i_cfg_wdata = 1'b0;
    logic                                      i_in_valid = 1'b0;
    logic                                      o_in_stall;
    logic                                      i_kind = 1'b0;
    logic [lpda_pkg::OPERAND_W-1:0]            i_first_operand = '0;
    logic [lpda_pkg::OPERAND_W-1:0]            i_second_operand = '0;
    logic signed [lpda_pkg::TABLE_VALUE_W-1:0] i_table_value = '0;
    logic                                      i_last = 1'b0;
    logic                                      o_out_valid;
    logic                                      i_out_stall = 1'b0;
    logic signed [lpda_pkg::SUM_W-1:0]         o_dot_sum;

    // Items waiting for the driver and sums waiting for the monitor.
    t_mac_item                                 pending_items[$];
    logic signed [lpda_pkg::SUM_W-1:0]         expected_sums[$];
    t_mac_item                                 next_item;

    // Mirror of the block state, updated as each transaction is accepted.
    logic signed [lpda_pkg::TABLE_VALUE_W-1:0] product_mirror [0:65535];
    logic signed [lpda_pkg::SUM_W-1:0]         sum_mirror = '0;
    logic                                      swap_setting = 1'b0;

    // Entries the stimulus has written, so no lookup ever hits an unwritten entry.
    bit                                        entry_loaded [0:65535];
    logic [15:0]                               loaded_addrs[$];

    logic                                      quiet = 1'b0;
    int                                        mismatch_count = 0;
    int                                        idle_cycles = 0;

    lut_product_dot_accumulate u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_table_value    (i_table_value),
        .i_last           (i_last),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_dot_sum        (o_dot_sum)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void predict_dot_step(
            input lpda_pkg::t_kind kind,
            input logic [lpda_pkg::OPERAND_W-1:0] first_op,
            input logic [lpda_pkg::OPERAND_W-1:0] second_op,
            input logic signed [lpda_pkg::TABLE_VALUE_W-1:0] value,
            input logic last);
        logic [15:0] lookup;
        if (kind == lpda_pkg::KIND_TABLE_WRITE) begin
            // Writes always address the table as row first, column second.
            product_mirror[{first_op, second_op}] = value;
        end else begin
            lookup = swap_setting ? {second_op, first_op} : {first_op, second_op};
            sum_mirror = sum_mirror + product_mirror[lookup];
            if (last) begin
                expected_sums.push_back(sum_mirror);
                sum_mirror = '0;
            end
        end
    endfunction

    task automatic queue_write(input logic [7:0] row, input logic [7:0] col,
                               input logic signed [15:0] value, input logic last);
        t_mac_item item;
        item.kind      = lpda_pkg::KIND_TABLE_WRITE;
        item.first_op  = row;
        item.second_op = col;
        item.value     = value;
        item.last      = last;
        pending_items.push_back(item);
        if (!entry_loaded[{row, col}]) begin
            entry_loaded[{row, col}] = 1'b1;
            loaded_addrs.push_back({row, col});
        end
    endtask

    task automatic queue_mac(input logic [7:0] first_op, input logic [7:0] second_op,
                             input logic last);
        t_mac_item item;
        item.kind      = lpda_pkg::KIND_MAC;
        item.first_op  = first_op;
        item.second_op = second_op;
        item.value     = 16'($urandom);
        item.last      = last;
        pending_items.push_back(item);
    endtask

    // Reads the table entry at addr, choosing operands to suit the current ordering.
    task automatic queue_mac_entry(input logic [15:0] addr, input logic last);
        if (swap_setting) begin
            queue_mac(addr[7:0], addr[15:8], last);
        end else begin
            queue_mac(addr[15:8], addr[7:0], last);
        end
    endtask

    task automatic queue_random_phase(input int count);
        int          n;
        int          pick;
        logic [15:0] addr;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                queue_write(8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
            end else if (pick < 30) begin
                // Write an entry and read it back at once to hit the read-after-write path.
                addr = 16'($urandom);
                queue_write(addr[15:8], addr[7:0], 16'($urandom), 1'($urandom));
                queue_mac_entry(addr, $urandom_range(3) == 0);
            end else begin
                addr = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
                queue_mac_entry(addr, $urandom_range(5) == 0);
            end
        end
    endtask

    task automatic wait_drained;
        do begin
            @(negedge i_clk);
        end while (pending_items.size() != 0 || i_in_valid || expected_sums.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_swap(input logic value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        swap_setting = value;
        @(negedge i_clk);
    endtask

    // Input driver: presents queued items and predicts each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_dot_step(lpda_pkg::t_kind'(i_kind), i_first_operand,
                                 i_second_operand, i_table_value, i_last);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 32)) begin
                    next_item = pending_items.pop_front();
                    i_kind           <= next_item.kind;
                    i_first_operand  <= next_item.first_op;
                    i_second_operand <= next_item.second_op;
                    i_table_value    <= next_item.value;
                    i_last           <= next_item.last;
                    i_in_valid       <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random output stalls, each accepted sum checked in order.
    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 32);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected dot_sum %0d", o_dot_sum));
            end else if (o_dot_sum !== expected_sums[0]) begin
                report_mismatch($sformatf("dot_sum %0d, expected %0d",
                                          o_dot_sum, expected_sums[0]));
                void'(expected_sums.pop_front());
            end else begin
                void'(expected_sums.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int phase;
        int n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset ordering: table extremes, then single and multi-element products.
        queue_write(8'h00, 8'h00, -16'sd32768, 1'b1);
        queue_write(8'hFF, 8'hFF, 16'sd32767, 1'b0);
        queue_write(8'h00, 8'hFF, -16'sd1, 1'b1);
        queue_write(8'hFF, 8'h00, 16'sd1, 1'b0);
        queue_write(8'h55, 8'hAA, 16'sh5555, 1'b0);
        queue_write(8'hAA, 8'h55, 16'shAAAA, 1'b0);
        queue_mac(8'h00, 8'h00, 1'b1);
        queue_mac(8'hFF, 8'hFF, 1'b0);
        queue_mac(8'h00, 8'hFF, 1'b0);
        queue_mac(8'hFF, 8'h00, 1'b1);
        queue_mac(8'h55, 8'hAA, 1'b0);
        queue_mac(8'hAA, 8'h55, 1'b1);
        queue_write(8'h12, 8'h34, 16'sd0, 1'b0);
        queue_mac(8'h12, 8'h34, 1'b1);

        // Swapped ordering; a write still uses first as row and second as column.
        write_swap(1'b1);
        queue_mac(8'hAA, 8'h55, 1'b1);
        queue_mac(8'hFF, 8'h00, 1'b0);
        queue_mac(8'h00, 8'hFF, 1'b1);
        queue_write(8'h12, 8'h34, 16'sd7, 1'b1);
        queue_mac(8'h34, 8'h12, 1'b1);

        // Longer products built from the most negative and most positive entries.
        write_swap(1'b0);
        for (n = 0; n < EXTREME_ITEMS; n++) begin
            queue_mac(8'h00, 8'h00, n == EXTREME_ITEMS - 1);
        end
        for (n = 0; n < EXTREME_ITEMS; n++) begin
            queue_mac(8'hFF, 8'hFF, n == EXTREME_ITEMS - 1);
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_swap((phase == 2) ? 1'b1 : 1'(phase + 1));
            quiet = (phase == 3);
            queue_random_phase(PHASE_ITEMS);
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
